### hw/rtl/linear_interp_resampler_macros.svh
// Assertion macros for the linear interpolation resampler.
// Used by the top level only; no dependencies.
`ifndef LINEAR_INTERP_RESAMPLER_MACROS_SVH
`define LINEAR_INTERP_RESAMPLER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LIR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LIR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/lir_pkg.sv
// Shared types, constants and the microcode table of the resampler.
// No dependencies; imported by every module of the block.
package lir_pkg;

   // default configuration
   localparam int LIR_MAX_RATIO   = 16;
   localparam int LIR_SAMPLE_BITS = 24;
   localparam int LIR_FRAC_BITS   = 16;

   // run index port is fixed at 4 bits
   localparam int IDX_BITS = 4;

   // register map
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_RATE        = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_INV_RATE    = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_START_PHASE = 2'd2;

   // microprogram steps
   localparam int STEP_BITS = 2;
   localparam logic [STEP_BITS-1:0] STEP_WAIT = 2'd0;
   localparam logic [STEP_BITS-1:0] STEP_COEF = 2'd1;
   localparam logic [STEP_BITS-1:0] STEP_MUL  = 2'd2;
   localparam logic [STEP_BITS-1:0] STEP_EMIT = 2'd3;

   // jump conditions
   localparam logic [1:0] COND_NONE     = 2'd0;
   localparam logic [1:0] COND_ALWAYS   = 2'd1;
   localparam logic [1:0] COND_CNT_ZERO = 2'd2;
   localparam logic [1:0] COND_MORE     = 2'd3;

   // one control word
   typedef struct packed {
      logic                 accept;     // take an input word
      logic                 mul_init;   // product <= (1 - phase) * inv_rate
      logic                 mul_lerp;   // product <= diff * coef
      logic                 coef_init;  // coef <= sat(product >> F)
      logic                 emit;       // load output word, step coef
      logic [1:0]           cond;       // jump condition
      logic [STEP_BITS-1:0] target;     // jump target
   } lir_ctrl_type;

   // datapath status seen by the sequencer
   typedef struct packed {
      logic req_valid;
      logic out_busy;
      logic count_zero;
      logic run_last;
   } lir_flags_type;

   // microcode ROM
   function automatic lir_ctrl_type lir_ucode(input logic [STEP_BITS-1:0] step);
      lir_ctrl_type cw;
      cw = '0;
      case (step)
         STEP_WAIT: begin
            cw.accept   = 1'b1;
            cw.mul_init = 1'b1;
            cw.cond     = COND_NONE;
         end
         STEP_COEF: begin
            cw.coef_init = 1'b1;
            cw.cond      = COND_CNT_ZERO;
            cw.target    = STEP_WAIT;
         end
         STEP_MUL: begin
            cw.mul_lerp = 1'b1;
            cw.cond     = COND_NONE;
         end
         STEP_EMIT: begin
            cw.emit   = 1'b1;
            cw.cond   = COND_MORE;
            cw.target = STEP_MUL;
         end
         default: begin
            cw = '0;
         end
      endcase
      return cw;
   endfunction

endpackage

### hw/rtl/lir_sequencer.sv
// Microcode sequencer: step counter, ROM lookup and conditional jumps.
// Depends on lir_pkg.
module lir_sequencer import lir_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  lir_flags_type flags,
   output lir_ctrl_type  ctrl
);

   logic [STEP_BITS-1:0] pc_ff, pc_in;
   logic                 hold;
   logic                 take;

   assign ctrl = lir_ucode(pc_ff);

   // next step: stall, jump or fall through (wraps to the wait step)
   always_comb begin
      hold = (ctrl.accept & ~flags.req_valid) | (ctrl.emit & flags.out_busy);
      case (ctrl.cond)
         COND_NONE:     take = 1'b0;
         COND_ALWAYS:   take = 1'b1;
         COND_CNT_ZERO: take = flags.count_zero;
         COND_MORE:     take = ~flags.run_last;
         default:       take = 1'b0;
      endcase
      if (hold) begin
         pc_in = pc_ff;
      end else if (take) begin
         pc_in = ctrl.target;
      end else begin
         pc_in = pc_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_WAIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

### hw/rtl/lir_datapath.sv
// Resampler datapath: sample history, phase, shared multiplier, coefficient
// and output register. Driven by lir_sequencer control words; uses lir_pkg.
module lir_datapath import lir_pkg::*; #(
   parameter int MAX_RATIO   = LIR_MAX_RATIO,
   parameter int SAMPLE_BITS = LIR_SAMPLE_BITS,
   parameter int FRAC_BITS   = LIR_FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lir_ctrl_type                  ctrl,
   input  logic [FRAC_BITS+4:0]          rate,
   input  logic [FRAC_BITS+8:0]          inv_rate,
   input  logic                          phase_load,
   input  logic [FRAC_BITS-1:0]          phase_value,
   input  logic                          req_valid,
   input  logic signed [SAMPLE_BITS-1:0] req_in_sample,
   input  logic                          rsp_ready,
   output lir_flags_type                 flags,
   output logic                          rsp_valid,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_sample,
   output logic [IDX_BITS-1:0]           rsp_run_index,
   output logic                          rsp_last
);

   localparam int MA = (SAMPLE_BITS + 1 > FRAC_BITS + 2) ? SAMPLE_BITS + 1 : FRAC_BITS + 2;
   localparam int MB = FRAC_BITS + 10;
   localparam int PW = MA + MB;
   localparam int CW = $clog2(MAX_RATIO + 1);
   localparam int SW = FRAC_BITS + 6;
   localparam logic [FRAC_BITS:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

   logic signed [SAMPLE_BITS-1:0] newest_ff, prev_ff;
   logic signed [SAMPLE_BITS:0]   diff_ff, diff_in;
   logic [FRAC_BITS-1:0]          phase_ff;
   logic [CW-1:0]                 count_ff, count_in;
   logic [CW-1:0]                 k_ff;
   logic [FRAC_BITS:0]            coef_ff;
   logic signed [PW-1:0]          prod_ff, prod_in;
   logic                          rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] out_ff, out_in;
   logic [IDX_BITS-1:0]           idx_ff;
   logic                          last_ff;

   logic [SW-1:0]          sum;
   logic [5:0]             count_raw;
   logic [FRAC_BITS:0]     one_minus_phase;
   logic signed [MA-1:0]   mul_a;
   logic signed [MB-1:0]   mul_b;
   logic [PW-FRAC_BITS-1:0] coef_hi;
   logic [FRAC_BITS+9:0]   coef_sum;
   logic signed [PW-1:0]   lerp_sh;
   logic                   accept_fire;
   logic                   emit_fire;
   logic                   out_busy;
   logic                   run_last;

   // handshake terms
   assign out_busy    = rsp_valid_ff & ~rsp_ready;
   assign accept_fire = ctrl.accept & req_valid;
   assign emit_fire   = ctrl.emit & ~out_busy;
   assign run_last    = (k_ff + 1'b1) == count_ff;

   assign flags.req_valid  = req_valid;
   assign flags.out_busy   = out_busy;
   assign flags.count_zero = (count_ff == '0);
   assign flags.run_last   = run_last;

   // phase advance and saturated run length
   always_comb begin
      sum       = SW'(phase_ff) + SW'(rate);
      count_raw = sum[SW-1:FRAC_BITS];
      if (7'(count_raw) > 7'(MAX_RATIO)) begin
         count_in = CW'(MAX_RATIO);
      end else begin
         count_in = CW'(count_raw);
      end
      diff_in = (SAMPLE_BITS+1)'(req_in_sample) - (SAMPLE_BITS+1)'(newest_ff);
   end

   // shared multiplier operand select
   always_comb begin
      one_minus_phase = ONE_Q - {1'b0, phase_ff};
      if (ctrl.mul_lerp) begin
         mul_a = MA'(diff_ff);
         mul_b = MB'(signed'({1'b0, coef_ff}));
      end else begin
         mul_a = MA'(signed'({1'b0, one_minus_phase}));
         mul_b = signed'({1'b0, inv_rate});
      end
      prod_in = PW'(mul_a) * PW'(mul_b);
   end

   // coefficient terms and interpolated sample
   always_comb begin
      coef_hi  = prod_ff[PW-1:FRAC_BITS];
      coef_sum = (FRAC_BITS+10)'(coef_ff) + (FRAC_BITS+10)'(inv_rate);
      lerp_sh  = prod_ff >>> FRAC_BITS;
      // result lies between prev and newest, so modulo arithmetic is exact
      out_in   = prev_ff + signed'(lerp_sh[SAMPLE_BITS-1:0]);
   end

   // sample history and phase
   always_ff @(posedge clock) begin
      if (reset) begin
         newest_ff <= '0;
         prev_ff   <= '0;
         phase_ff  <= '0;
         count_ff  <= '0;
      end else begin
         if (phase_load) begin
            phase_ff <= phase_value;
         end else if (accept_fire) begin
            phase_ff <= sum[FRAC_BITS-1:0];
         end
         if (accept_fire) begin
            newest_ff <= req_in_sample;
            prev_ff   <= newest_ff;
            count_ff  <= count_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept_fire) begin
         diff_ff <= diff_in;
      end
      if (ctrl.mul_init | ctrl.mul_lerp) begin
         prod_ff <= prod_in;
      end
      if (ctrl.coef_init) begin
         if (coef_hi > (PW-FRAC_BITS)'(ONE_Q)) begin
            coef_ff <= ONE_Q;
         end else begin
            coef_ff <= coef_hi[FRAC_BITS:0];
         end
      end else if (emit_fire) begin
         if (coef_sum > (FRAC_BITS+10)'(ONE_Q)) begin
            coef_ff <= ONE_Q;
         end else begin
            coef_ff <= coef_sum[FRAC_BITS:0];
         end
      end
      if (emit_fire) begin
         out_ff  <= out_in;
         idx_ff  <= IDX_BITS'(k_ff);
         last_ff <= run_last;
      end
   end

   // run position counter
   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= '0;
      end else if (accept_fire) begin
         k_ff <= '0;
      end else if (emit_fire) begin
         k_ff <= k_ff + 1'b1;
      end
   end

   // output word valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_sample = out_ff;
   assign rsp_run_index  = idx_ff;
   assign rsp_last       = last_ff;

endmodule

### hw/rtl/linear_interp_resampler.sv
// Linear interpolation sample rate converter, top level.
// Holds the configuration registers and joins lir_sequencer and lir_datapath.
// Depends on lir_pkg and linear_interp_resampler_macros.svh.
//
// Usage:
//   req_*  : one input sample word per handshake (valid/ready).
//   rsp_*  : interpolated output words; run_index counts within the run of
//            one input, last marks its final word. A run may be empty.
//   csr_*  : register writes (index 0 rate, 1 inv_rate, 2 start_phase);
//            csr_ready is always high. Write only while the block is idle.
//            A start_phase write loads the phase at once.
// Timing: an input taking n outputs (n up to MAX_RATIO) passes the wait and
//   coefficient steps, then a multiply and an emit step per output; the single
//   shared multiplier runs once per output and once for the first coefficient.
//   Each output word is registered at its emit step.
// Stalls: an output word sits in a register; the sequencer waits at the
//   emit step while that register is still full and not being taken.
// Reset: rate and inv_rate = 1.0, phase and sample history = 0, no output
//   pending; the block is ready for input as soon as reset is released.
`include "linear_interp_resampler_macros.svh"

module linear_interp_resampler import lir_pkg::*; #(
   parameter int MAX_RATIO   = LIR_MAX_RATIO,
   parameter int SAMPLE_BITS = LIR_SAMPLE_BITS,
   parameter int FRAC_BITS   = LIR_FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_in_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_sample,
   output logic [IDX_BITS-1:0]           rsp_run_index,
   output logic                          rsp_last,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [FRAC_BITS+8:0]          csr_wdata
);

   localparam int RATE_W = FRAC_BITS + 5;
   localparam int INV_W  = FRAC_BITS + 9;

   logic [RATE_W-1:0]    rate_ff;
   logic [INV_W-1:0]     inv_rate_ff;
   logic                 csr_fire;
   logic                 phase_load;
   lir_ctrl_type         ctrl;
   lir_flags_type        flags;

   // configuration write decode
   assign csr_ready  = 1'b1;
   assign csr_fire   = csr_valid & csr_ready;
   assign phase_load = csr_fire & (csr_index == REG_START_PHASE);

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff     <= RATE_W'(1) << FRAC_BITS;
         inv_rate_ff <= INV_W'(1) << FRAC_BITS;
      end else if (csr_fire) begin
         case (csr_index)
            REG_RATE:     rate_ff     <= csr_wdata[RATE_W-1:0];
            REG_INV_RATE: inv_rate_ff <= csr_wdata[INV_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign req_ready = ctrl.accept;

   lir_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   lir_datapath #(
      .MAX_RATIO   (MAX_RATIO),
      .SAMPLE_BITS (SAMPLE_BITS),
      .FRAC_BITS   (FRAC_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (ctrl),
      .rate           (rate_ff),
      .inv_rate       (inv_rate_ff),
      .phase_load     (phase_load),
      .phase_value    (csr_wdata[FRAC_BITS-1:0]),
      .req_valid      (req_valid),
      .req_in_sample  (req_in_sample),
      .rsp_ready      (rsp_ready),
      .flags          (flags),
      .rsp_valid      (rsp_valid),
      .rsp_out_sample (rsp_out_sample),
      .rsp_run_index  (rsp_run_index),
      .rsp_last       (rsp_last)
   );

   // sequencing checks
   `LIR_ASSERT_NEXT(a_accept_then_coef, clock, reset, req_valid && req_ready, ctrl.coef_init, "accepted word not followed by coefficient step")
   `LIR_ASSERT_NEXT(a_empty_run_returns, clock, reset, ctrl.coef_init && flags.count_zero, ctrl.accept, "empty run did not return to wait")
   `LIR_ASSERT_NEXT(a_emit_gives_valid, clock, reset, ctrl.emit && !flags.out_busy, rsp_valid, "emitted word not presented")
   `LIR_ASSERT_NEXT(a_last_returns, clock, reset, ctrl.emit && !flags.out_busy && flags.run_last, ctrl.accept, "final word of run did not return to wait")

endmodule
